[rtl/core/rolling_hash_pattern_matcher_assert.svh]
// Assertion macros used by the matcher sequencer.
`ifndef ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH
`define ROLLING_HASH_PATTERN_MATCHER_ASSERT_SVH

// Clocked check, muted while reset is asserted.
`define RHPM_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Clocked check that also holds through reset.
`define RHPM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

[rtl/core/rhpm_pkg.sv]
package rhpm_pkg;

    localparam int MAX_PATTERN = 16;
    localparam int HASH_BASE   = 256;
    localparam int PAT_BYTES   = 16;
    localparam int RED_STEPS   = 8;
    localparam logic [15:0] MOD_RESET = 16'd10;
    localparam logic [15:0] POS_MAX   = 16'hFFFF;

    typedef enum logic [1:0] {
        REG_LENGTH  = 2'd0,
        REG_MODULUS = 2'd1,
        REG_PAT_LO  = 2'd2,
        REG_PAT_HI  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [4:0]   len;
        logic [15:0]  md;    // effective modulus, never below one
        logic [127:0] pat;
    } t_cfg;

    typedef enum logic [2:0] {
        SRC_WEIGHT = 3'd0,   // acc * base
        SRC_PAT    = 3'd1,   // acc * base + pattern[k]
        SRC_WIN    = 3'd2,   // acc * base + window[k-1]
        SRC_DROP   = 3'd3,   // window[m-1] * weight
        SRC_BYTE   = 3'd4    // acc * base + new byte
    } t_red_src;

    typedef enum logic [2:0] {
        ACC_HOLD    = 3'd0,
        ACC_UNIT    = 3'd1,
        ACC_ZERO    = 3'd2,
        ACC_REM     = 3'd3,
        ACC_HASH    = 3'd4,
        ACC_SUBDROP = 3'd5
    } t_acc_op;

    typedef enum logic [2:0] {
        K_HOLD = 3'd0,
        K_ONE  = 3'd1,
        K_ZERO = 3'd2,
        K_FILL = 3'd3,
        K_INC  = 3'd4,
        K_DEC  = 3'd5
    } t_k_op;

    typedef enum logic [1:0] {
        HASH_HOLD = 2'd0,
        HASH_ACC  = 2'd1,
        HASH_REM  = 2'd2
    } t_hash_op;

    typedef struct packed {
        logic     red_start;
        t_red_src red_src;
        t_acc_op  acc_op;
        t_k_op    k_op;
        t_hash_op hash_op;
        logic     wgt_load;
        logic     phash_load;
        logic     in_take;
        logic     shift;
        logic     vfy_clear;
        logic     vfy_step;
        logic     out_load;
    } t_cmd;

    typedef struct packed {
        logic red_done;
        logic k_lt_m;
        logic k_nz;
        logic len_zero;
        logic pos_ge_m;
        logic hit;
        logic out_free;
        logic out_full;
    } t_sts;

endpackage

[rtl/core/rolling_hash_pattern_matcher.sv]
// Rolling-hash pattern matcher: one text byte per transfer, one optional result per byte.
// The block takes no new byte until it is through with the last one. Once the window is full each
// byte takes two passes of the shared shift-subtract remainder unit (drop, then roll), one while
// it fills and none at zero length; a verify step per pattern byte follows when the hashes agree.
// A register write starts a refresh of the weight, the pattern hash and the window hash.
// Reset is synchronous, active low; a refresh runs after reset before the first transfer.
module rolling_hash_pattern_matcher #(
    parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // config port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready,
    // text in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tuser,   // [0] first_of_text
    // results out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] window_start
    output logic        m_axis_tuser    // [0] hit_kind
);

    rhpm_pkg::t_cfg cfg;
    rhpm_pkg::t_cmd cmd;
    rhpm_pkg::t_sts sts;
    logic           cfg_wr;

    // Registers: length, modulus and the two pattern words, 8 bytes apart.
    rhpm_regs u_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_cfg    (cfg),
        .o_cfg_wr (cfg_wr)
    );

    // Sequencer: refresh of weight and hashes, then per byte drop, roll, verify, emit.
    rhpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr    (cfg_wr),
        .i_in_tvalid (s_axis_tvalid),
        .o_in_tready (s_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // Window, hashes, remainder unit and the result register that holds
    // a finished result while the next byte is already being worked on.
    rhpm_datapath #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (cfg),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_text_byte     (s_axis_tdata),
        .i_first_of_text (s_axis_tuser),
        .i_out_tready    (m_axis_tready),
        .o_out_tvalid    (m_axis_tvalid),
        .o_window_start  (m_axis_tdata),
        .o_hit_kind      (m_axis_tuser)
    );

endmodule

[rtl/core/rhpm_regs.sv]
module rhpm_regs (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [63:0]        pwdata,
    output logic [63:0]        prdata,
    output logic               pready,
    output rhpm_pkg::t_cfg     o_cfg,
    output logic               o_cfg_wr
);

    logic [4:0]  r_len;
    logic [15:0] r_md;
    logic [63:0] r_pat_lo;
    logic [63:0] r_pat_hi;
    rhpm_pkg::t_reg_idx idx;

    assign idx      = rhpm_pkg::t_reg_idx'(paddr[4:3]);
    assign pready   = 1'b1;
    assign o_cfg_wr = psel & penable & pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len    <= '0;
            r_md     <= rhpm_pkg::MOD_RESET;
            r_pat_lo <= '0;
            r_pat_hi <= '0;
        end else if (o_cfg_wr) begin
            unique case (idx)
                rhpm_pkg::REG_LENGTH:  r_len    <= pwdata[4:0];
                rhpm_pkg::REG_MODULUS: r_md     <= pwdata[15:0];
                rhpm_pkg::REG_PAT_LO:  r_pat_lo <= pwdata;
                rhpm_pkg::REG_PAT_HI:  r_pat_hi <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            rhpm_pkg::REG_LENGTH:  prdata = 64'(r_len);
            rhpm_pkg::REG_MODULUS: prdata = 64'(r_md);
            rhpm_pkg::REG_PAT_LO:  prdata = r_pat_lo;
            rhpm_pkg::REG_PAT_HI:  prdata = r_pat_hi;
            default:               prdata = '0;
        endcase
    end

    // a modulus of zero or one acts as one
    assign o_cfg.len = r_len;
    assign o_cfg.md  = (r_md < 16'd2) ? 16'd1 : r_md;
    assign o_cfg.pat = {r_pat_hi, r_pat_lo};

endmodule

[rtl/core/rhpm_datapath.sv]
module rhpm_datapath #(
    parameter int MAX_PATTERN = rhpm_pkg::MAX_PATTERN
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rhpm_pkg::t_cfg  i_cfg,
    input  rhpm_pkg::t_cmd  i_cmd,
    output rhpm_pkg::t_sts  o_sts,
    input  logic [7:0]      i_text_byte,
    input  logic            i_first_of_text,
    input  logic            i_out_tready,
    output logic            o_out_tvalid,
    output logic [15:0]     o_window_start,
    output logic            o_hit_kind
);

    localparam int KW   = $clog2(MAX_PATTERN + 1);
    localparam int IW   = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int CW   = $clog2(rhpm_pkg::RED_STEPS + 1);
    localparam logic [KW-1:0] MaxP = KW'(MAX_PATTERN);

    logic [7:0]    r_win [MAX_PATTERN];
    logic [15:0]   r_seen;
    logic [15:0]   r_hash;
    logic [15:0]   r_wgt;
    logic [15:0]   r_phash;
    logic [15:0]   r_acc;
    logic [15:0]   r_rem;
    logic [7:0]    r_lo;
    logic [CW-1:0] r_cnt;
    logic [KW-1:0] r_k;
    logic          r_equal;
    logic [7:0]    r_byte;
    logic [15:0]   r_start;
    logic          r_out_valid;
    logic [15:0]   r_out_start;
    logic          r_out_kind;

    logic [KW-1:0] m;
    logic [KW-1:0] n;
    logic [KW-1:0] win_addr;
    logic [7:0]    win_rd;
    logic [3:0]    k4;
    logic [7:0]    pat_rd;
    logic [15:0]   mul_a;
    logic [8:0]    mul_b;
    logic [7:0]    mul_c;
    logic [24:0]   mul_x;
    logic [16:0]   red_t;
    logic [16:0]   red_r;
    logic [16:0]   sub_s;
    logic [15:0]   sub_r;

    assign m = (32'(i_cfg.len) > 32'(MAX_PATTERN)) ? MaxP : KW'(i_cfg.len);
    assign n = (r_seen < 16'(m)) ? KW'(r_seen) : m;

    // single window read port
    always_comb begin
        if (i_cmd.red_start && i_cmd.red_src == rhpm_pkg::SRC_WIN) begin
            win_addr = r_k - KW'(1);
        end else if (i_cmd.vfy_step) begin
            win_addr = m - KW'(1) - r_k;
        end else begin
            win_addr = m - KW'(1);
        end
    end
    assign win_rd = r_win[IW'(win_addr)];

    // pattern bytes past sixteen read as zero
    assign k4     = 4'(r_k);
    assign pat_rd = (32'(r_k) < rhpm_pkg::PAT_BYTES) ? i_cfg.pat[8*k4 +: 8] : 8'd0;

    always_comb begin
        mul_a = r_acc;
        mul_b = 9'(rhpm_pkg::HASH_BASE);
        mul_c = 8'd0;
        case (i_cmd.red_src)
            rhpm_pkg::SRC_PAT:  mul_c = pat_rd;
            rhpm_pkg::SRC_WIN:  mul_c = win_rd;
            rhpm_pkg::SRC_BYTE: mul_c = r_byte;
            rhpm_pkg::SRC_DROP: begin
                mul_a = r_wgt;
                mul_b = 9'(win_rd);
            end
            default: ;
        endcase
    end
    assign mul_x = 25'(mul_a) * 25'(mul_b) + 25'(mul_c);

    // restoring remainder: upper part is already below the modulus
    assign red_t = {r_rem, r_lo[7]};
    assign red_r = (red_t >= 17'(i_cfg.md)) ? red_t - 17'(i_cfg.md) : red_t;

    assign sub_s = 17'(r_hash) + 17'(i_cfg.md) - 17'(r_rem);
    assign sub_r = (sub_s >= 17'(i_cfg.md)) ? 16'(sub_s - 17'(i_cfg.md)) : 16'(sub_s);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else if (i_cmd.red_start) begin
            r_cnt <= CW'(rhpm_pkg::RED_STEPS);
        end else if (r_cnt != '0) begin
            r_cnt <= r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.red_start) begin
            r_rem <= mul_x[23:8];
            r_lo  <= mul_x[7:0];
        end else if (r_cnt != '0) begin
            r_rem <= red_r[15:0];
            r_lo  <= {r_lo[6:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_cmd.acc_op)
            rhpm_pkg::ACC_UNIT:    r_acc <= (i_cfg.md == 16'd1) ? 16'd0 : 16'd1;
            rhpm_pkg::ACC_ZERO:    r_acc <= '0;
            rhpm_pkg::ACC_REM:     r_acc <= r_rem;
            rhpm_pkg::ACC_HASH:    r_acc <= r_hash;
            rhpm_pkg::ACC_SUBDROP: r_acc <= sub_r;
            default: ;
        endcase
        case (i_cmd.k_op)
            rhpm_pkg::K_ONE:  r_k <= KW'(1);
            rhpm_pkg::K_ZERO: r_k <= '0;
            rhpm_pkg::K_FILL: r_k <= n;
            rhpm_pkg::K_INC:  r_k <= r_k + KW'(1);
            rhpm_pkg::K_DEC:  r_k <= r_k - KW'(1);
            default: ;
        endcase
        if (i_cmd.wgt_load) begin
            r_wgt <= r_acc;
        end
        if (i_cmd.phash_load) begin
            r_phash <= r_acc;
        end
        if (i_cmd.in_take) begin
            r_byte <= i_text_byte;
        end
        if (i_cmd.vfy_clear) begin
            r_equal <= 1'b1;
        end else if (i_cmd.vfy_step && win_rd != pat_rd) begin
            r_equal <= 1'b0;
        end
        if (i_cmd.shift) begin
            r_start <= (r_seen == rhpm_pkg::POS_MAX) ? rhpm_pkg::POS_MAX
                                                     : r_seen + 16'd1 - 16'(m);
        end
        if (i_cmd.out_load) begin
            r_out_start <= r_start;
            r_out_kind  <= ~r_equal;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                r_win[i] <= '0;
            end
            r_seen      <= '0;
            r_hash      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.in_take && i_first_of_text) begin
                for (int i = 0; i < MAX_PATTERN; i++) begin
                    r_win[i] <= '0;
                end
                r_seen <= '0;
                r_hash <= '0;
            end else begin
                if (i_cmd.shift) begin
                    r_win[0] <= r_byte;
                    for (int i = 1; i < MAX_PATTERN; i++) begin
                        r_win[i] <= r_win[i-1];
                    end
                    if (r_seen != rhpm_pkg::POS_MAX) begin
                        r_seen <= r_seen + 16'd1;
                    end
                end
                case (i_cmd.hash_op)
                    rhpm_pkg::HASH_ACC: r_hash <= r_acc;
                    rhpm_pkg::HASH_REM: r_hash <= r_rem;
                    default: ;
                endcase
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_sts.red_done = (r_cnt == '0);
    assign o_sts.k_lt_m   = (r_k < m);
    assign o_sts.k_nz     = (r_k != '0);
    assign o_sts.len_zero = (m == '0);
    assign o_sts.pos_ge_m = (r_seen >= 16'(m));
    assign o_sts.hit      = (17'(r_seen) + 17'd1 >= 17'(m)) && (r_rem == r_phash);
    assign o_sts.out_free = ~r_out_valid | i_out_tready;
    assign o_sts.out_full = r_out_valid;

    assign o_out_tvalid   = r_out_valid;
    assign o_window_start = r_out_start;
    assign o_hit_kind     = r_out_kind;

endmodule

[rtl/core/rhpm_ctrl.sv]
`include "rolling_hash_pattern_matcher_assert.svh"

module rhpm_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_wr,
    input  logic            i_in_tvalid,
    output logic            o_in_tready,
    input  rhpm_pkg::t_sts  i_sts,
    output rhpm_pkg::t_cmd  o_cmd
);

    typedef enum logic [13:0] {
        ST_REF_INIT  = 14'b00000000000001,
        ST_REF_W_CHK = 14'b00000000000010,
        ST_REF_W_RED = 14'b00000000000100,
        ST_REF_P_CHK = 14'b00000000001000,
        ST_REF_P_RED = 14'b00000000010000,
        ST_REF_H_CHK = 14'b00000000100000,
        ST_REF_H_RED = 14'b00000001000000,
        ST_IDLE      = 14'b00000010000000,
        ST_START     = 14'b00000100000000,
        ST_DROP_RED  = 14'b00001000000000,
        ST_ROLL_ST   = 14'b00010000000000,
        ST_ROLL_RED  = 14'b00100000000000,
        ST_VERIFY    = 14'b01000000000000,
        ST_EMIT      = 14'b10000000000000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   in_xfer;

    assign o_in_tready = (r_state == ST_IDLE) & ~i_cfg_wr;
    assign in_xfer     = o_in_tready & i_in_tvalid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            ST_REF_INIT: begin
                o_cmd.acc_op = rhpm_pkg::ACC_UNIT;
                o_cmd.k_op   = rhpm_pkg::K_ONE;
                n_state      = ST_REF_W_CHK;
            end
            ST_REF_W_CHK: begin
                if (i_sts.k_lt_m) begin
                    o_cmd.red_start = 1'b1;
                    o_cmd.red_src   = rhpm_pkg::SRC_WEIGHT;
                    n_state         = ST_REF_W_RED;
                end else begin
                    o_cmd.wgt_load = 1'b1;
                    o_cmd.acc_op   = rhpm_pkg::ACC_ZERO;
                    o_cmd.k_op     = rhpm_pkg::K_ZERO;
                    n_state        = ST_REF_P_CHK;
                end
            end
            ST_REF_W_RED: begin
                if (i_sts.red_done) begin
                    o_cmd.acc_op = rhpm_pkg::ACC_REM;
                    o_cmd.k_op   = rhpm_pkg::K_INC;
                    n_state      = ST_REF_W_CHK;
                end
            end
            ST_REF_P_CHK: begin
                if (i_sts.k_lt_m) begin
                    o_cmd.red_start = 1'b1;
                    o_cmd.red_src   = rhpm_pkg::SRC_PAT;
                    n_state         = ST_REF_P_RED;
                end else begin
                    o_cmd.phash_load = 1'b1;
                    o_cmd.acc_op     = rhpm_pkg::ACC_ZERO;
                    o_cmd.k_op       = rhpm_pkg::K_FILL;
                    n_state          = ST_REF_H_CHK;
                end
            end
            ST_REF_P_RED: begin
                if (i_sts.red_done) begin
                    o_cmd.acc_op = rhpm_pkg::ACC_REM;
                    o_cmd.k_op   = rhpm_pkg::K_INC;
                    n_state      = ST_REF_P_CHK;
                end
            end
            ST_REF_H_CHK: begin
                if (i_sts.k_nz) begin
                    o_cmd.red_start = 1'b1;
                    o_cmd.red_src   = rhpm_pkg::SRC_WIN;
                    n_state         = ST_REF_H_RED;
                end else begin
                    o_cmd.hash_op = rhpm_pkg::HASH_ACC;
                    n_state       = ST_IDLE;
                end
            end
            ST_REF_H_RED: begin
                if (i_sts.red_done) begin
                    o_cmd.acc_op = rhpm_pkg::ACC_REM;
                    o_cmd.k_op   = rhpm_pkg::K_DEC;
                    n_state      = ST_REF_H_CHK;
                end
            end
            ST_IDLE: begin
                if (in_xfer) begin
                    o_cmd.in_take = 1'b1;
                    n_state       = ST_START;
                end
            end
            ST_START: begin
                if (i_sts.len_zero) begin
                    o_cmd.shift = 1'b1;
                    n_state     = ST_IDLE;
                end else if (i_sts.pos_ge_m) begin
                    o_cmd.red_start = 1'b1;
                    o_cmd.red_src   = rhpm_pkg::SRC_DROP;
                    n_state         = ST_DROP_RED;
                end else begin
                    o_cmd.acc_op = rhpm_pkg::ACC_HASH;
                    n_state      = ST_ROLL_ST;
                end
            end
            ST_DROP_RED: begin
                if (i_sts.red_done) begin
                    o_cmd.acc_op = rhpm_pkg::ACC_SUBDROP;
                    n_state      = ST_ROLL_ST;
                end
            end
            ST_ROLL_ST: begin
                o_cmd.red_start = 1'b1;
                o_cmd.red_src   = rhpm_pkg::SRC_BYTE;
                n_state         = ST_ROLL_RED;
            end
            ST_ROLL_RED: begin
                if (i_sts.red_done) begin
                    o_cmd.hash_op = rhpm_pkg::HASH_REM;
                    o_cmd.shift   = 1'b1;
                    if (i_sts.hit) begin
                        o_cmd.k_op      = rhpm_pkg::K_ZERO;
                        o_cmd.vfy_clear = 1'b1;
                        n_state         = ST_VERIFY;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_VERIFY: begin
                if (i_sts.k_lt_m) begin
                    o_cmd.vfy_step = 1'b1;
                    o_cmd.k_op     = rhpm_pkg::K_INC;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_REF_INIT;
        endcase
        // any register write restarts the refresh
        if (i_cfg_wr) begin
            n_state = ST_REF_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_REF_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    `RHPM_ASSERT(a_accept_leaves_idle, in_xfer |=> (r_state != ST_IDLE), "accept did not leave idle")
    `RHPM_ASSERT(a_load_into_free_slot, o_cmd.out_load |-> i_sts.out_free, "result load over a full slot")
    `RHPM_ASSERT(a_result_from_emit, $rose(i_sts.out_full) |-> $past(r_state == ST_EMIT), "result raised outside emit")
    `RHPM_ASSERT_ALWAYS(a_ready_only_idle, o_in_tready |-> (r_state == ST_IDLE), "ready outside idle")

endmodule
